// ----- src/hpp_pkg.sv -----
// Package: shared types, character codes and byte class codes for the HTTP request parser.
package hpp_pkg;

  localparam int BYTE_W  = 8;
  localparam int CLASS_W = 3;
  localparam int LEN_W   = 17;
  localparam int OUT_W   = 16;

  localparam int QUEUE_DEPTH = 4;

  typedef logic [CLASS_W-1:0] byte_class_t;

  localparam byte_class_t CLS_METHOD = 3'd0;
  localparam byte_class_t CLS_SEP    = 3'd1;
  localparam byte_class_t CLS_URI    = 3'd2;
  localparam byte_class_t CLS_HEADER = 3'd3;
  localparam byte_class_t CLS_BODY   = 3'd4;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_C     = 8'h43;

  // "Content-Length:" is 15 characters; the match index reaches this on a full hit
  localparam logic [3:0] FIELD_LEN = 4'd15;

  localparam logic [LEN_W-1:0] LEN_SAT = 17'h1FFFF;

  // one decoded byte on its way from the front end to the back end
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              is_space;
    logic              is_nul;
    logic              is_digit;
    logic [3:0]        digit;
    logic              is_cr;
    logic              is_c;
  } token_t;

  function automatic logic [BYTE_W-1:0] field_char(input logic [3:0] idx);
    logic [BYTE_W-1:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h43; // C
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h4C; // L
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      4'd14:   ch = 8'h3A; // :
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

// ----- src/hpp_if.sv -----
// Interfaces: request byte channel and parse result channel.
interface hpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hpp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_class;
  logic [7:0]  byte_out;
  logic        request_done;
  logic        malformed;
  logic        request_line_ok;
  logic        has_length;
  logic [16:0] body_length;
  logic [15:0] method_length;
  logic [15:0] uri_length;
  logic [15:0] header_length;

  modport source (
    output valid, output byte_class, output byte_out, output request_done,
    output malformed, output request_line_ok, output has_length, output body_length,
    output method_length, output uri_length, output header_length,
    input ready
  );
  modport sink (
    input valid, input byte_class, input byte_out, input request_done,
    input malformed, input request_line_ok, input has_length, input body_length,
    input method_length, input uri_length, input header_length,
    output ready
  );
endinterface

// ----- src/http_request_header_parser_unit.sv -----
// Top level: HTTP request header parser, one byte per cycle while the result channel is not stalled.
//
// Takes a request one byte per transaction on the request channel and returns one
// result transaction per byte: the byte itself, its class (method, separator, uri,
// header or body) and, on the byte marked last, the verdict and the lengths of the
// method, uri and header, with the Content-Length value if one was found. After the
// last byte the parser is back at its start state, so the next request may follow
// in the very next cycle. Sustained rate is one byte per clock cycle while the result
// channel is not stalled, set by the back-end state update, which needs the previous
// byte's outcome before the next. An accepted byte passes through the token queue and
// then the result register before its result is shown. The front end keeps accepting
// while a result waits downstream until the four-entry queue and the result
// register are full, i.e. five bytes in flight. MAX_REQUEST_BYTES bounds the byte
// counter (longer requests report malformed); MAX_LENGTH_DIGITS caps the number of
// Content-Length digits taken. No clearing pass is needed after reset.
module http_request_header_parser_unit import hpp_pkg::*; #(
  parameter int MAX_REQUEST_BYTES = 65535,
  parameter int MAX_LENGTH_DIGITS = 5
) (
  input  logic      clk,
  input  logic      rst,
  hpp_in_if.sink    request,
  hpp_out_if.source result
);

  // decoded bytes, front end to queue
  token_t fe_tok;
  logic   fe_valid;
  logic   fe_ready;

  // queue to back end
  token_t q_tok;
  logic   q_valid;
  logic   q_ready;

  // character decode at the input; ready simply follows queue space
  hpp_front u_front (
    .request   (request),
    .tok       (fe_tok),
    .tok_valid (fe_valid),
    .tok_ready (fe_ready)
  );

  // decouples input acceptance from result back-pressure
  hpp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (fe_tok),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .rd_data  (q_tok),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  // parse state machine; pulls a token whenever the result register is free
  // or being drained in the same cycle
  hpp_back #(
    .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES),
    .MAX_LENGTH_DIGITS (MAX_LENGTH_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok       (q_tok),
    .tok_valid (q_valid),
    .tok_ready (q_ready),
    .result    (result)
  );

endmodule

// ----- src/hpp_front.sv -----
// Front end: accepts request bytes and decodes the character classes the parser needs.
module hpp_front import hpp_pkg::*; (
  hpp_in_if.sink   request,
  output token_t   tok,
  output logic     tok_valid,
  input  logic     tok_ready
);

  assign tok_valid     = request.valid;
  assign request.ready = tok_ready;

  always_comb begin
    tok.data     = request.data_byte;
    tok.last     = request.last_byte;
    tok.is_space = (request.data_byte == CH_SPACE);
    tok.is_nul   = (request.data_byte == CH_NUL);
    tok.is_digit = (request.data_byte >= CH_ZERO) && (request.data_byte <= CH_NINE);
    tok.digit    = request.data_byte[3:0]; // low nibble of an ASCII digit is its value
    tok.is_cr    = (request.data_byte == CH_CR);
    tok.is_c     = (request.data_byte == CH_C);
  end

endmodule

// ----- src/hpp_queue.sv -----
// Short token queue between the front end and the back end.
module hpp_queue import hpp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  token_t wr_data,
  input  logic   wr_valid,
  output logic   wr_ready,
  output token_t rd_data,
  output logic   rd_valid,
  input  logic   rd_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [NW-1:0] FULL_CNT  = NW'(DEPTH);

  token_t          slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [NW-1:0]   fill;
  logic            push;
  logic            pop;

  assign wr_ready = (fill != FULL_CNT);
  assign rd_valid = (fill != '0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= wr_data;
        wr_ptr        <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- src/hpp_back.sv -----
// Back end: request parsing state machine and registered result stage.
module hpp_back import hpp_pkg::*; #(
  parameter int MAX_REQUEST_BYTES = 65535,
  parameter int MAX_LENGTH_DIGITS = 5
) (
  input  logic      clk,
  input  logic      rst,
  input  token_t    tok,
  input  logic      tok_valid,
  output logic      tok_ready,
  hpp_out_if.source result
);

  localparam int CW  = $clog2(MAX_REQUEST_BYTES + 1);
  localparam int DCW = $clog2(MAX_LENGTH_DIGITS + 1);
  localparam int PW  = LEN_W + 4;
  localparam logic [CW-1:0]  BC_MAX = CW'(MAX_REQUEST_BYTES);
  localparam logic [DCW-1:0] DC_MAX = DCW'(MAX_LENGTH_DIGITS);

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_SEP,
    PH_URI,
    PH_HEADER,
    PH_BODY
  } phase_t;

  typedef struct packed {
    byte_class_t       byte_class;
    logic [BYTE_W-1:0] byte_out;
    logic              request_done;
    logic              malformed;
    logic              request_line_ok;
    logic              has_length;
    logic [LEN_W-1:0]  body_length;
    logic [OUT_W-1:0]  method_length;
    logic [OUT_W-1:0]  uri_length;
    logic [OUT_W-1:0]  header_length;
  } result_t;

  phase_t           phase, phase_next;
  logic [CW-1:0]    byte_count, byte_count_next;
  logic [CW-1:0]    method_count, method_count_next;
  logic [CW-1:0]    uri_count, uri_count_next;
  logic [3:0]       field_idx, field_idx_next;
  logic [DCW-1:0]   digit_count, digit_count_next;
  logic [LEN_W-1:0] length_value, length_value_next;
  logic [1:0]       blank_idx, blank_idx_next;
  logic [CW-1:0]    header_end_pos, header_end_pos_next;
  logic             f_haslen, f_haslen_next;
  logic             f_digdone, f_digdone_next;
  logic             f_blank, f_blank_next;
  logic             f_stop, f_stop_next;
  logic             f_ovf, f_ovf_next;

  logic             out_valid;
  result_t          out_res;
  result_t          res_next;

  logic             pop;
  logic             active;
  logic             do_blank;
  logic [2:0]       blank_inc;
  logic [BYTE_W-1:0] want;
  logic [PW-1:0]    prod;
  logic [LEN_W-1:0] lv_dig;
  logic [DCW-1:0]   dc_inc;
  logic [CW-1:0]    body_bytes;
  logic             bad;
  byte_class_t      cls;

  assign tok_ready = !out_valid || result.ready;
  assign pop       = tok_valid && tok_ready;

  always_comb begin
    phase_next          = phase;
    byte_count_next     = byte_count;
    method_count_next   = method_count;
    uri_count_next      = uri_count;
    field_idx_next      = field_idx;
    digit_count_next    = digit_count;
    length_value_next   = length_value;
    blank_idx_next      = blank_idx;
    header_end_pos_next = header_end_pos;
    f_haslen_next       = f_haslen;
    f_digdone_next      = f_digdone;
    f_blank_next        = f_blank;
    f_stop_next         = f_stop;
    f_ovf_next          = f_ovf;
    do_blank            = 1'b0;
    cls                 = CLS_METHOD;

    if (byte_count >= BC_MAX) begin
      f_ovf_next  = 1'b1;
      f_stop_next = 1'b1;
    end else begin
      byte_count_next = byte_count + 1'b1;
    end
    if (tok.is_nul) begin
      f_stop_next = 1'b1;
    end
    active = !f_stop_next;

    // length * 10 + digit, saturating
    prod   = (PW'(length_value) << 3) + (PW'(length_value) << 1) + PW'(tok.digit);
    lv_dig = (prod > PW'(LEN_SAT)) ? LEN_SAT : prod[LEN_W-1:0];
    dc_inc = digit_count + 1'b1;

    unique case (phase)
      PH_METHOD: begin
        cls = CLS_METHOD;
        if (active) begin
          if (tok.is_space) begin
            phase_next = PH_SEP;
            cls        = CLS_SEP;
          end else begin
            method_count_next = method_count + 1'b1;
          end
        end
      end
      PH_SEP: begin
        cls = CLS_SEP;
        if (active && !tok.is_space) begin
          phase_next     = PH_URI;
          cls            = CLS_URI;
          uri_count_next = CW'(1);
        end
      end
      PH_URI: begin
        cls = CLS_URI;
        if (active) begin
          if (tok.is_space) begin
            phase_next = PH_HEADER;
            cls        = CLS_SEP;
          end else begin
            uri_count_next = uri_count + 1'b1;
          end
        end
      end
      PH_HEADER: begin
        cls = CLS_HEADER;
        if (active) begin
          if (!f_haslen) begin
            if (field_idx < FIELD_LEN && tok.data == field_char(field_idx)) begin
              field_idx_next = field_idx + 1'b1;
            end else begin
              field_idx_next = tok.is_c ? 4'd1 : 4'd0;
            end
            if (field_idx_next == FIELD_LEN) begin
              f_haslen_next = 1'b1;
            end
          end else if (!f_digdone) begin
            if (digit_count == '0 && tok.is_space) begin
              // leading space before the digits
            end else if (tok.is_digit) begin
              length_value_next = lv_dig;
              digit_count_next  = dc_inc;
              if (dc_inc >= DC_MAX) begin
                f_digdone_next = 1'b1;
              end
            end else begin
              f_digdone_next = 1'b1;
              do_blank       = 1'b1;
            end
          end else if (!f_blank) begin
            do_blank = 1'b1;
          end
        end
      end
      PH_BODY: begin
        cls = CLS_BODY;
      end
      default: begin
        cls = CLS_METHOD;
      end
    endcase

    // CR LF CR LF search
    want      = blank_idx[0] ? CH_LF : CH_CR;
    blank_inc = {1'b0, blank_idx} + 3'd1;
    if (do_blank) begin
      if (tok.data == want) begin
        if (blank_inc == 3'd4) begin
          blank_idx_next      = 2'd0;
          f_blank_next        = 1'b1;
          header_end_pos_next = byte_count_next;
          phase_next          = PH_BODY;
        end else begin
          blank_idx_next = blank_inc[1:0];
        end
      end else begin
        blank_idx_next = tok.is_cr ? 2'd1 : 2'd0;
      end
    end

    body_bytes = byte_count_next - header_end_pos_next;
    bad = f_ovf_next ||
          (f_haslen_next && (!f_blank_next || (LEN_W'(body_bytes) != length_value_next)));

    res_next            = '0;
    res_next.byte_class = cls;
    res_next.byte_out   = tok.data;
    if (tok.last) begin
      res_next.request_done    = 1'b1;
      res_next.malformed       = bad;
      res_next.request_line_ok = (phase_next == PH_HEADER) || (phase_next == PH_BODY);
      res_next.has_length      = f_haslen_next;
      res_next.body_length     = length_value_next;
      res_next.method_length   = OUT_W'(method_count_next);
      res_next.uri_length      = OUT_W'(uri_count_next);
      res_next.header_length   = (f_haslen_next && f_blank_next) ?
                                 OUT_W'(header_end_pos_next) : OUT_W'(byte_count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_METHOD;
      byte_count     <= '0;
      method_count   <= '0;
      uri_count      <= '0;
      field_idx      <= '0;
      digit_count    <= '0;
      length_value   <= '0;
      blank_idx      <= '0;
      header_end_pos <= '0;
      f_haslen       <= 1'b0;
      f_digdone      <= 1'b0;
      f_blank        <= 1'b0;
      f_stop         <= 1'b0;
      f_ovf          <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (pop) begin
        if (tok.last) begin
          // request finished: back to the start for the next one
          phase          <= PH_METHOD;
          byte_count     <= '0;
          method_count   <= '0;
          uri_count      <= '0;
          field_idx      <= '0;
          digit_count    <= '0;
          length_value   <= '0;
          blank_idx      <= '0;
          header_end_pos <= '0;
          f_haslen       <= 1'b0;
          f_digdone      <= 1'b0;
          f_blank        <= 1'b0;
          f_stop         <= 1'b0;
          f_ovf          <= 1'b0;
        end else begin
          phase          <= phase_next;
          byte_count     <= byte_count_next;
          method_count   <= method_count_next;
          uri_count      <= uri_count_next;
          field_idx      <= field_idx_next;
          digit_count    <= digit_count_next;
          length_value   <= length_value_next;
          blank_idx      <= blank_idx_next;
          header_end_pos <= header_end_pos_next;
          f_haslen       <= f_haslen_next;
          f_digdone      <= f_digdone_next;
          f_blank        <= f_blank_next;
          f_stop         <= f_stop_next;
          f_ovf          <= f_ovf_next;
        end
        out_res   <= res_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid           = out_valid;
  assign result.byte_class      = out_res.byte_class;
  assign result.byte_out        = out_res.byte_out;
  assign result.request_done    = out_res.request_done;
  assign result.malformed       = out_res.malformed;
  assign result.request_line_ok = out_res.request_line_ok;
  assign result.has_length      = out_res.has_length;
  assign result.body_length     = out_res.body_length;
  assign result.method_length   = out_res.method_length;
  assign result.uri_length      = out_res.uri_length;
  assign result.header_length   = out_res.header_length;

endmodule

// ----- src/hpp_checker.sv -----
// Checker: port-level assertions on the parser's result channel, bound to the top level.
module hpp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  byte_class,
  input logic [7:0]  byte_out,
  input logic        request_done,
  input logic        malformed,
  input logic        request_line_ok,
  input logic        has_length,
  input logic [16:0] body_length,
  input logic [15:0] method_length,
  input logic [15:0] uri_length,
  input logic [15:0] header_length
);

  // a stalled result keeps its contents
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(byte_class)
      && $stable(request_done) && $stable(header_length))
    else $error("result changed while stalled");

  // summary fields are zero except on the final byte of a request
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !request_done |-> !malformed && !request_line_ok && !has_length
      && body_length == 17'd0 && method_length == 16'd0 && uri_length == 16'd0
      && header_length == 16'd0)
    else $error("summary field set before end of request");

  // the length field is only searched after a complete request line
  a_len_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_length |-> request_line_ok)
    else $error("length found without a request line");

  // no Content-Length field means no length value
  a_no_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && request_done && !has_length |-> body_length == 17'd0)
    else $error("length value without a length field");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind http_request_header_parser_unit hpp_checker u_hpp_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .byte_class      (result.byte_class),
  .byte_out        (result.byte_out),
  .request_done    (result.request_done),
  .malformed       (result.malformed),
  .request_line_ok (result.request_line_ok),
  .has_length      (result.has_length),
  .body_length     (result.body_length),
  .method_length   (result.method_length),
  .uri_length      (result.uri_length),
  .header_length   (result.header_length)
);
